// ----- rtl/core/rlt_pkg.sv -----
// ----------------------------------------------------------------------------
// RMS level tracker package
// Shared widths, reset values, payload types and state encodings.
// ----------------------------------------------------------------------------
package rlt_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int GAIN_W    = 4;
	localparam int THR_W     = 19;
	localparam int ALPHA_W   = 16;
	localparam int LEVEL_W   = 19;
	localparam int ACC_W     = 36;
	localparam int SUM_W     = 48;
	localparam int SQ_W      = 38;
	localparam int ROOT_W    = 24;
	localparam int MCAND_W   = 36;
	localparam int MPLR_W    = 19;
	localparam int PROD_W    = MCAND_W + MPLR_W;
	localparam int CFG_W     = 19;
	localparam int CFG_IDX_W = 2;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 19'd491520;
	localparam logic [GAIN_W-1:0]  GAIN_RST  = 4'd5;
	localparam logic [THR_W-1:0]   THR_RST   = 19'd6554;
	localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd4588;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN      = 2'd0,
		CFG_THRESHOLD = 2'd1,
		CFG_ALPHA     = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       block_end;
	} item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] smoothed_level;
		logic [LEVEL_W-1:0] block_rms;
		logic               trigger;
	} result_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ACCUM,
		ST_ROOT,
		ST_LVL_MUL,
		ST_RMS_MUL,
		ST_TRIG,
		ST_EMIT
	} ctl_state_t;

	typedef enum logic [1:0] {
		DS_IDLE,
		DS_DIV,
		DS_SQRT
	} ds_phase_t;

endpackage

// ----- rtl/core/rms_level_tracker_with_trigger_core.sv -----
// ----------------------------------------------------------------------------
// RMS level tracker with trigger
// Accumulates squared, gain-scaled samples per block; at block end computes
// the block RMS, blends it into a smoothed level and updates the trigger.
// ----------------------------------------------------------------------------
// Each sample is squared by the bit-serial multiplier and accumulated before
// the next one can be accepted.
// A block-ending sample is squared and accumulated, then runs through the
// divide/root unit (48 quotient bits, 24 root bits) until its root is taken,
// then two serial multiplies, and then the trigger update and output.
// Its result waits in an output register, which holds further input only
// while the previous result waits.
// Reset is asynchronous and active low; it clears the sums, level, trigger,
// the output valid and loads the register defaults.
module rms_level_tracker_with_trigger_core #(
	parameter int MAX_BLOCK = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  rlt_pkg::item_t                 item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output rlt_pkg::result_t               result,
	input  logic                           cfg_we,
	input  logic [rlt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rlt_pkg::CFG_W-1:0]      cfg_data
);
	import rlt_pkg::*;

	localparam int CNT_W = $clog2(MAX_BLOCK + 1);
	localparam logic [CNT_W-1:0] BLOCK_LIMIT = CNT_W'(MAX_BLOCK);

	ctl_state_t           state_q;
	ctl_state_t           state_d;

	logic [GAIN_W-1:0]    gain_q;
	logic [THR_W-1:0]     thr_q;
	logic [ALPHA_W-1:0]   alpha_q;

	logic [CNT_W-1:0]     count_q;
	logic [SUM_W-1:0]     sum_q;
	logic [ACC_W-1:0]     level_q;
	logic                 trig_q;
	logic                 last_q;
	logic [LEVEL_W-1:0]   rms_q;
	logic [ACC_W-1:0]     hi_q;
	result_t              res_q;
	logic                 res_valid_q;

	logic [SAMPLE_W:0]    mag;
	logic [SAMPLE_W+GAIN_W:0] scaled_full;
	logic [LEVEL_W-1:0]   scaled;
	logic [CNT_W-1:0]     count_nx;
	logic                 item_last;
	logic [SUM_W:0]       sum_ext;
	logic [SUM_W-1:0]     sum_sat;
	logic [LEVEL_W-1:0]   rms_w;
	logic [ALPHA_W:0]     one_minus_alpha;
	logic [ACC_W-1:0]     level_new;
	logic [ACC_W-1:0]     thr_ext;
	logic                 out_free;
	logic                 accept;

	logic                 mul_start;
	logic [MCAND_W-1:0]   mul_mcand;
	logic [MPLR_W-1:0]    mul_mplr;
	logic [PROD_W-1:0]    mul_prod;
	unit_stat_t           mul_stat;
	logic                 ds_start;
	logic [ROOT_W-1:0]    ds_root;
	unit_stat_t           ds_stat;

	rlt_sermul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (mul_mcand),
		.mplr    (mul_mplr),
		.product (mul_prod),
		.stat    (mul_stat)
	);

	rlt_divsqrt #(
		.CNT_W (CNT_W)
	) u_divsqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ds_start),
		.dividend (sum_sat),
		.divisor  (count_q),
		.root     (ds_root),
		.stat     (ds_stat)
	);

	always_comb begin
		mag = item.sample[SAMPLE_W-1]
			? (SAMPLE_W+1)'(17'h10000 - {1'b0, item.sample})
			: {1'b0, item.sample};
		scaled_full = (SAMPLE_W+GAIN_W+1)'(mag) * (SAMPLE_W+GAIN_W+1)'(gain_q);
		scaled      = scaled_full[LEVEL_W-1:0];
		count_nx    = count_q + 1'b1;
		// A block also closes when it reaches the maximum length.
		item_last   = item.block_end || (count_nx >= BLOCK_LIMIT);

		sum_ext = {1'b0, sum_q} + (SUM_W+1)'(mul_prod[SQ_W-1:0]);
		sum_sat = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];

		rms_w = (ds_root > ROOT_W'(LEVEL_MAX)) ? LEVEL_MAX : ds_root[LEVEL_W-1:0];
		one_minus_alpha = 17'h10000 - {1'b0, alpha_q};
		// The alpha-weighted RMS term already has 16 fraction bits, so only
		// the level term needs its low half dropped.
		level_new = hi_q + mul_prod[ACC_W-1:0];
		thr_ext   = {1'b0, thr_q, 16'b0};
		out_free  = !res_valid_q || result_ready;
		accept    = item_valid && item_ready;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) state_d = ST_SQUARE;
			end
			ST_SQUARE: begin
				if (mul_stat.done) state_d = ST_ACCUM;
			end
			ST_ACCUM: begin
				state_d = last_q ? ST_ROOT : ST_IDLE;
			end
			ST_ROOT: begin
				if (ds_stat.done) state_d = ST_LVL_MUL;
			end
			ST_LVL_MUL: begin
				if (mul_stat.done) state_d = ST_RMS_MUL;
			end
			ST_RMS_MUL: begin
				if (mul_stat.done) state_d = ST_TRIG;
			end
			ST_TRIG: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready = 1'b0;
		mul_start  = 1'b0;
		mul_mcand  = MCAND_W'(scaled);
		mul_mplr   = scaled;
		ds_start   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				mul_start  = item_valid;
			end
			ST_ACCUM: begin
				ds_start = last_q;
			end
			ST_ROOT: begin
				mul_start = ds_stat.done;
				mul_mcand = level_q;
				mul_mplr  = MPLR_W'(one_minus_alpha);
			end
			ST_LVL_MUL: begin
				mul_start = mul_stat.done;
				mul_mcand = MCAND_W'(rms_q);
				mul_mplr  = MPLR_W'(alpha_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gain_q      <= GAIN_RST;
			thr_q       <= THR_RST;
			alpha_q     <= ALPHA_RST;
			count_q     <= '0;
			sum_q       <= '0;
			level_q     <= '0;
			trig_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_GAIN:      gain_q  <= cfg_data[GAIN_W-1:0];
					CFG_THRESHOLD: thr_q   <= cfg_data[THR_W-1:0];
					CFG_ALPHA:     alpha_q <= cfg_data[ALPHA_W-1:0];
					default: ;
				endcase
			end
			if (accept) count_q <= count_nx;
			if (state_q == ST_ACCUM) begin
				if (last_q) begin
					sum_q   <= '0;
					count_q <= '0;
				end else begin
					sum_q <= sum_sat;
				end
			end
			if (state_q == ST_RMS_MUL && mul_stat.done) level_q <= level_new;
			// An exact match with the threshold keeps the previous flag.
			if (state_q == ST_TRIG) begin
				if (level_q > thr_ext) begin
					trig_q <= 1'b1;
				end else if (level_q < thr_ext) begin
					trig_q <= 1'b0;
				end
			end
			if (state_q == ST_EMIT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) last_q <= item_last;
		if (state_q == ST_ROOT && ds_stat.done) rms_q <= rms_w;
		if (state_q == ST_LVL_MUL && mul_stat.done) hi_q <= mul_prod[ACC_W+15:16];
		if (state_q == ST_EMIT && out_free) begin
			res_q.smoothed_level <= level_q[LEVEL_W+15:16];
			res_q.block_rms      <= rms_q;
			res_q.trigger        <= trig_q;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

`ifndef NO_ASSERTIONS
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= BLOCK_LIMIT)
		else $error("sample count went past the block limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= {1'b0, LEVEL_MAX, 16'b0})
		else $error("smoothed level exceeds full-scale bound");

	assert property (@(posedge clk) disable iff (!arst_n)
		ds_start |-> (!mul_stat.busy && !ds_stat.busy))
		else $error("divide/root started while an arithmetic unit is busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_free) |=> result_valid)
		else $error("block result was not presented after emit");
`endif

endmodule

// ----- rtl/core/rlt_sermul.sv -----
// ----------------------------------------------------------------------------
// RLT serial multiplier
// Shift-and-add multiplier, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module rlt_sermul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [rlt_pkg::MCAND_W-1:0]  mcand,
	input  logic [rlt_pkg::MPLR_W-1:0]   mplr,
	output logic [rlt_pkg::PROD_W-1:0]   product,
	output rlt_pkg::unit_stat_t          stat
);
	import rlt_pkg::*;

	localparam int STEP_W = $clog2(MPLR_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MPLR_W - 1);

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	logic [PROD_W-1:0]   p_q;
	logic [MCAND_W-1:0]  mcand_q;
	logic [MCAND_W:0]    psum;
	logic [PROD_W-1:0]   p_next;

	// The upper half collects partial sums while the multiplier bits
	// shift out of the lower half.
	always_comb begin
		psum = {1'b0, p_q[PROD_W-1:MPLR_W]} + (p_q[0] ? {1'b0, mcand_q} : '0);
		p_next = {psum, p_q[MPLR_W-1:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			p_q     <= {{MCAND_W{1'b0}}, mplr};
			mcand_q <= mcand;
		end else if (busy_q) begin
			p_q <= p_next;
		end
	end

	assign product   = p_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- rtl/core/rlt_divsqrt.sv -----
// ----------------------------------------------------------------------------
// RLT divide and square root unit
// Restoring division of the square sum by the sample count, one quotient
// bit per cycle, then a bit-pair square root of the quotient.
// ----------------------------------------------------------------------------
module rlt_divsqrt #(
	parameter int CNT_W = 9
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rlt_pkg::SUM_W-1:0]   dividend,
	input  logic [CNT_W-1:0]            divisor,
	output logic [rlt_pkg::ROOT_W-1:0]  root,
	output rlt_pkg::unit_stat_t         stat
);
	import rlt_pkg::*;

	localparam int STEP_W = $clog2(SUM_W);
	localparam int SREM_W = ROOT_W + 2;
	localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W - 1);
	localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);

	ds_phase_t            phase_q;
	ds_phase_t            phase_d;
	logic [STEP_W-1:0]    step_q;
	logic                 done_q;

	// The quotient shifts into the same register that then feeds the root.
	logic [SUM_W-1:0]     rad_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W-1:0]     div_q;
	logic [SREM_W-1:0]    srem_q;
	logic [ROOT_W-1:0]    root_q;

	logic [CNT_W:0]       dtrial;
	logic [CNT_W:0]       ddiff;
	logic                 dge;
	logic [CNT_W-1:0]     rem_nx;
	logic [SREM_W+1:0]    strial;
	logic [SREM_W+1:0]    ssub;
	logic [SREM_W+1:0]    sdiff;
	logic                 sge;
	logic [SREM_W-1:0]    srem_nx;

	always_comb begin
		dtrial = {rem_q, rad_q[SUM_W-1]};
		ddiff  = dtrial - {1'b0, div_q};
		dge    = (dtrial >= {1'b0, div_q});
		rem_nx = dge ? ddiff[CNT_W-1:0] : dtrial[CNT_W-1:0];

		strial  = {srem_q, rad_q[SUM_W-1 -: 2]};
		ssub    = {2'b00, root_q, 2'b01};
		sdiff   = strial - ssub;
		sge     = (strial >= ssub);
		srem_nx = sge ? sdiff[SREM_W-1:0] : strial[SREM_W-1:0];
	end

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			DS_IDLE: begin
				if (start) phase_d = DS_DIV;
			end
			DS_DIV: begin
				if (step_q == DIV_LAST) phase_d = DS_SQRT;
			end
			DS_SQRT: begin
				if (step_q == SQRT_LAST) phase_d = DS_IDLE;
			end
			default: phase_d = DS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= DS_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (phase_d != phase_q) begin
				step_q <= '0;
			end else if (phase_q != DS_IDLE) begin
				step_q <= step_q + 1'b1;
			end
			done_q <= (phase_q == DS_SQRT) && (step_q == SQRT_LAST);
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			DS_IDLE: begin
				if (start) begin
					rad_q <= dividend;
					div_q <= divisor;
					rem_q <= '0;
				end
			end
			DS_DIV: begin
				rad_q <= {rad_q[SUM_W-2:0], dge};
				rem_q <= rem_nx;
				if (step_q == DIV_LAST) begin
					srem_q <= '0;
					root_q <= '0;
				end
			end
			DS_SQRT: begin
				rad_q  <= {rad_q[SUM_W-3:0], 2'b00};
				srem_q <= srem_nx;
				root_q <= {root_q[ROOT_W-2:0], sge};
			end
			default: ;
		endcase
	end

	assign root      = root_q;
	assign stat.busy = (phase_q != DS_IDLE);
	assign stat.done = done_q;

endmodule
